// ===== rtl/core/tlam_pkg.sv =====
// ----------------------------------------------------------------------------
// tlam_pkg
// Shared types and codes for the tensor layout address map.
// ----------------------------------------------------------------------------
package tlam_pkg;

    localparam int MAX_DIMS = 4;

    localparam logic [1:0] CMD_LOG_ENC = 2'd0;
    localparam logic [1:0] CMD_PHY_ENC = 2'd1;
    localparam logic [1:0] CMD_PHY_DEC = 2'd2;
    localparam logic [1:0] CMD_LOG_DEC = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOB  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic [2:0] REG_ORDER   = 3'd0;
    localparam logic [2:0] REG_EXTENTS = 3'd1;
    localparam logic [2:0] REG_PADS    = 3'd2;
    localparam logic [2:0] REG_STRIDE0 = 3'd3;
    localparam logic [2:0] REG_STRIDE1 = 3'd4;
    localparam logic [2:0] REG_STRIDE2 = 3'd5;
    localparam logic [2:0] REG_STRIDE3 = 3'd6;

    typedef struct packed {
        logic [7:0]            order;
        logic [3:0][15:0]      extents;
        logic [3:0][15:0]      pads;
        logic [3:0][31:0]      stride;
    } cfg_t;

    // Payload that travels down the divider pipeline.
    typedef struct packed {
        logic [1:0]            cmd;
        logic                  oob;
        logic                  zero;
        logic [31:0]           enc;
        logic [31:0]           num;
        logic [31:0]           rmd;
        logic [3:0][31:0]      quo;
    } pipe_t;

endpackage

// ===== rtl/core/tlam_front.sv =====
// ----------------------------------------------------------------------------
// tlam_front
// Permute, pad and bound check, stride multiply, then offset sum (3 stages).
// ----------------------------------------------------------------------------
module tlam_front #(
    parameter int NUM_DIMS    = 4,
    parameter int COORD_BITS  = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  tlam_pkg::cfg_t       cfg,
    input  logic                 in_vld,
    input  logic [1:0]           cmd,
    input  logic [3:0][15:0]     coord,
    input  logic [31:0]          linear,
    output logic                 out_vld,
    output tlam_pkg::pipe_t      out_pipe
);

    localparam logic [31:0] OFS_MASK = 32'((64'd1 << OFFSET_BITS) - 64'd1);

    logic signed [3:0][17:0] crd;
    logic signed [3:0][17:0] p_next;
    logic                    oob_next;
    logic                    zero_next;
    logic [1:0]              src;

    logic                    a_vld_reg;
    logic [1:0]              a_cmd_reg;
    logic signed [3:0][17:0] a_p_reg;
    logic                    a_oob_reg;
    logic                    a_zero_reg;
    logic [31:0]             a_num_reg;

    logic signed [50:0]      mul;
    logic [3:0][31:0]        prod_next;
    logic                    b_vld_reg;
    logic [1:0]              b_cmd_reg;
    logic [3:0][31:0]        b_prod_reg;
    logic                    b_oob_reg;
    logic                    b_zero_reg;
    logic [31:0]             b_num_reg;

    logic                    c_vld_reg;
    tlam_pkg::pipe_t         c_pipe_reg;
    tlam_pkg::pipe_t         c_pipe_next;

    always_comb
    begin
        oob_next  = 1'b0;
        zero_next = 1'b0;
        src       = 2'd0;
        for (int i = 0; i < tlam_pkg::MAX_DIMS; i++)
        begin
            crd[i] = 18'(signed'(coord[i][COORD_BITS-1:0]));
        end
        for (int i = 0; i < tlam_pkg::MAX_DIMS; i++)
        begin
            p_next[i] = '0;
            if (i < NUM_DIMS)
            begin
                src = cfg.order[2*i +: 2];
                if (cmd == tlam_pkg::CMD_LOG_ENC)
                begin
                    p_next[i] = (32'(src) < 32'(NUM_DIMS)) ? crd[src] : '0;
                end
                else
                begin
                    p_next[i] = crd[i];
                end
                p_next[i] = p_next[i] + $signed({2'b00, cfg.pads[i]});
                // elements of a packed array are unsigned; compare as signed
                if ($signed(p_next[i]) < 0 ||
                    $signed(p_next[i]) >= $signed({2'b00, cfg.extents[i]}))
                begin
                    oob_next = 1'b1;
                end
                if (cfg.stride[i] == '0)
                begin
                    zero_next = 1'b1;
                end
            end
        end
    end

    // stage A
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_cmd_reg  <= cmd;
            a_p_reg    <= p_next;
            a_oob_reg  <= oob_next;
            a_zero_reg <= zero_next;
            a_num_reg  <= linear & OFS_MASK;
        end
    end

    // stage B: one 33x18 multiply per dimension
    always_comb
    begin
        mul = '0;
        for (int i = 0; i < tlam_pkg::MAX_DIMS; i++)
        begin
            mul          = $signed({1'b0, cfg.stride[i]}) * $signed(a_p_reg[i]);
            prod_next[i] = mul[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_cmd_reg  <= a_cmd_reg;
            b_prod_reg <= prod_next;
            b_oob_reg  <= a_oob_reg;
            b_zero_reg <= a_zero_reg;
            b_num_reg  <= a_num_reg;
        end
    end

    // stage C: sum of products, wraps modulo the offset width
    always_comb
    begin
        c_pipe_next      = '0;
        c_pipe_next.cmd  = b_cmd_reg;
        c_pipe_next.oob  = b_oob_reg;
        c_pipe_next.zero = b_zero_reg;
        c_pipe_next.enc  = (b_prod_reg[0] + b_prod_reg[1] + b_prod_reg[2] + b_prod_reg[3])
                           & OFS_MASK;
        c_pipe_next.num  = b_num_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_pipe_reg <= c_pipe_next;
        end
    end

    assign out_vld  = c_vld_reg;
    assign out_pipe = c_pipe_reg;

endmodule

// ===== rtl/core/tlam_div_stage.sv =====
// ----------------------------------------------------------------------------
// tlam_div_stage
// One restoring-division step: one quotient bit of one dimension.
// ----------------------------------------------------------------------------
module tlam_div_stage #(
    parameter int OFFSET_BITS = 32,
    parameter int DIM_IDX     = 0,
    parameter bit FIRST_BIT   = 1'b1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic [31:0]          stride,
    input  logic                 in_vld,
    input  tlam_pkg::pipe_t      in_pipe,
    output logic                 out_vld,
    output tlam_pkg::pipe_t      out_pipe
);

    localparam logic [31:0] OFS_MASK = 32'((64'd1 << OFFSET_BITS) - 64'd1);

    logic [31:0]     cur_n;
    logic [31:0]     cur_r;
    logic [32:0]     r_sh;
    logic            ge;
    tlam_pkg::pipe_t pipe_next;
    logic            vld_reg;
    tlam_pkg::pipe_t pipe_reg;

    always_comb
    begin
        // a new dimension starts from the previous remainder
        if (FIRST_BIT && DIM_IDX > 0)
        begin
            cur_n = in_pipe.rmd;
            cur_r = '0;
        end
        else
        begin
            cur_n = in_pipe.num;
            cur_r = in_pipe.rmd;
        end
        r_sh = {cur_r, cur_n[OFFSET_BITS-1]};
        ge   = r_sh >= {1'b0, stride};
        pipe_next              = in_pipe;
        pipe_next.rmd          = ge ? 32'(r_sh - {1'b0, stride}) : r_sh[31:0];
        pipe_next.num          = (cur_n << 1) & OFS_MASK;
        pipe_next.quo[DIM_IDX] = {in_pipe.quo[DIM_IDX][30:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_reg <= pipe_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_pipe = pipe_reg;

endmodule

// ===== rtl/core/tlam_back.sv =====
// ----------------------------------------------------------------------------
// tlam_back
// Pad removal, bound check, inverse permutation, saturation; output register.
// ----------------------------------------------------------------------------
module tlam_back #(
    parameter int NUM_DIMS    = 4,
    parameter int OFFSET_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  tlam_pkg::cfg_t       cfg,
    input  logic                 in_vld,
    input  tlam_pkg::pipe_t      in_pipe,
    output logic                 out_vld,
    output logic [31:0]          offset,
    output logic [3:0][31:0]     coords,
    output logic [1:0]           status
);

    localparam logic [31:0] OFS_MASK = 32'((64'd1 << OFFSET_BITS) - 64'd1);

    logic signed [33:0]  phys;
    logic [3:0][31:0]    sat;
    logic [3:0][31:0]    res;
    logic                oob;
    logic [1:0]          dst;
    logic                vld_reg;
    logic [31:0]         offset_reg;
    logic [3:0][31:0]    coords_reg;
    logic [1:0]          status_reg;
    logic [31:0]         offset_next;
    logic [1:0]          status_next;

    always_comb
    begin
        oob  = 1'b0;
        phys = '0;
        dst  = 2'd0;
        for (int i = 0; i < tlam_pkg::MAX_DIMS; i++)
        begin
            phys = $signed({2'b00, in_pipe.quo[i] & OFS_MASK}) - $signed({18'd0, cfg.pads[i]});
            if (phys > 34'sd2147483647)
            begin
                sat[i] = 32'h7fff_ffff;
            end
            else
            begin
                sat[i] = phys[31:0];
            end
            if (i < NUM_DIMS && (in_pipe.quo[i] & OFS_MASK) >= {16'd0, cfg.extents[i]})
            begin
                oob = 1'b1;
            end
        end
        res = '0;
        for (int i = 0; i < tlam_pkg::MAX_DIMS; i++)
        begin
            if (i < NUM_DIMS)
            begin
                if (in_pipe.cmd == tlam_pkg::CMD_LOG_DEC)
                begin
                    dst = cfg.order[2*i +: 2];
                    if (32'(dst) < 32'(NUM_DIMS))
                    begin
                        res[dst] = sat[i];
                    end
                end
                else
                begin
                    res[i] = sat[i];
                end
            end
        end
        if (in_pipe.cmd == tlam_pkg::CMD_LOG_ENC || in_pipe.cmd == tlam_pkg::CMD_PHY_ENC)
        begin
            offset_next = in_pipe.enc;
            status_next = in_pipe.oob ? tlam_pkg::ST_OOB : tlam_pkg::ST_OK;
            res         = '0;
        end
        else if (in_pipe.zero)
        begin
            offset_next = '0;
            status_next = tlam_pkg::ST_ZERO;
            res         = '0;
        end
        else
        begin
            offset_next = '0;
            status_next = oob ? tlam_pkg::ST_OOB : tlam_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            offset_reg <= offset_next;
            coords_reg <= res;
            status_reg <= status_next;
        end
    end

    assign out_vld = vld_reg;
    assign offset  = offset_reg;
    assign coords  = coords_reg;
    assign status  = status_reg;

endmodule

// ===== rtl/core/tensor_layout_address_map_top.sv =====
// ----------------------------------------------------------------------------
// tensor_layout_address_map_top
// Maps tensor coordinates to linear offsets and back for a padded, strided,
// dimension-permuted layout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): command, coord_a..coord_d, linear_in.
//   Output channel (out_valid/out_ready): entry_offset, out_a..out_d, status.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   always ready; write only while no transfer is in flight.
//   Every item passes through three front stages (permute and pad, stride
//   multiply, offset sum), a pipelined restoring divider with one quotient
//   bit per stage for every dimension, and one output stage. Every item,
//   encode or decode, takes the same path so results leave in order.
//   Throughput is one transfer per cycle on each side while the receiver
//   keeps out_ready high.
//   Reset clears all valid bits and loads the register reset values
//   (identity order, extents of 1, no padding, unit strides).
//   While the receiver stalls with a result waiting, the whole pipeline
//   holds and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module tensor_layout_address_map_top #(
    parameter int NUM_DIMS    = 4,
    parameter int COORD_BITS  = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic signed [15:0] coord_a,
    input  logic signed [15:0] coord_b,
    input  logic signed [15:0] coord_c,
    input  logic signed [15:0] coord_d,
    input  logic [31:0]        linear_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        entry_offset,
    output logic signed [31:0] out_a,
    output logic signed [31:0] out_b,
    output logic signed [31:0] out_c,
    output logic signed [31:0] out_d,
    output logic [1:0]         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    localparam int NDIV = NUM_DIMS * OFFSET_BITS;

    tlam_pkg::cfg_t    cfg;
    logic [7:0]        dim_order_reg;
    logic [63:0]       dim_extents_reg;
    logic [63:0]       dim_pads_reg;
    logic [3:0][31:0]  stride_reg;

    logic              adv;
    logic              vld [0:NDIV];
    tlam_pkg::pipe_t   stg [0:NDIV];
    logic [3:0][15:0]  coord;
    logic [3:0][31:0]  coords;

    // Config registers; an index beyond the list is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_order_reg   <= 8'd228;
            dim_extents_reg <= 64'h0001_0001_0001_0001;
            dim_pads_reg    <= '0;
            stride_reg      <= {4{32'd1}};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tlam_pkg::REG_ORDER:   dim_order_reg   <= cfg_data[7:0];
                tlam_pkg::REG_EXTENTS: dim_extents_reg <= cfg_data;
                tlam_pkg::REG_PADS:    dim_pads_reg    <= cfg_data;
                tlam_pkg::REG_STRIDE0: stride_reg[0]   <= cfg_data[31:0];
                tlam_pkg::REG_STRIDE1: stride_reg[1]   <= cfg_data[31:0];
                tlam_pkg::REG_STRIDE2: stride_reg[2]   <= cfg_data[31:0];
                tlam_pkg::REG_STRIDE3: stride_reg[3]   <= cfg_data[31:0];
                default:               ;
            endcase
        end
    end

    assign cfg.order   = dim_order_reg;
    assign cfg.extents = dim_extents_reg;
    assign cfg.pads    = dim_pads_reg;
    assign cfg.stride  = stride_reg;

    // Single pipeline enable: every stage moves when the output slot frees.
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    assign coord = {coord_d, coord_c, coord_b, coord_a};

    tlam_front #(
        .NUM_DIMS    (NUM_DIMS),
        .COORD_BITS  (COORD_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .cfg      (cfg),
        .in_vld   (in_valid),
        .cmd      (command),
        .coord    (coord),
        .linear   (linear_in),
        .out_vld  (vld[0]),
        .out_pipe (stg[0])
    );

    // Divider chain: dimensions outermost first, quotient MSB first.
    for (genvar k = 0; k < NDIV; k++)
    begin : g_div
        localparam int DIM = k / OFFSET_BITS;
        localparam bit FST = (k % OFFSET_BITS) == 0;
        tlam_div_stage #(
            .OFFSET_BITS (OFFSET_BITS),
            .DIM_IDX     (DIM),
            .FIRST_BIT   (FST)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .stride   (stride_reg[DIM]),
            .in_vld   (vld[k]),
            .in_pipe  (stg[k]),
            .out_vld  (vld[k+1]),
            .out_pipe (stg[k+1])
        );
    end

    tlam_back #(
        .NUM_DIMS    (NUM_DIMS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .cfg     (cfg),
        .in_vld  (vld[NDIV]),
        .in_pipe (stg[NDIV]),
        .out_vld (out_valid),
        .offset  (entry_offset),
        .coords  (coords),
        .status  (status)
    );

    assign out_a = coords[0];
    assign out_b = coords[1];
    assign out_c = coords[2];
    assign out_d = coords[3];

    // A zero-stride decode result carries cleared coordinates and a zero offset.
    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == tlam_pkg::ST_ZERO |->
            out_a == 0 && out_b == 0 && out_c == 0 && out_d == 0 && entry_offset == 0)
        else $error("zero-stride result carries data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == tlam_pkg::ST_OK || status == tlam_pkg::ST_OOB ||
                      status == tlam_pkg::ST_ZERO)
        else $error("undefined status code");

    // An empty output slot never blocks the input side.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // A held result's offset and status do not change while the receiver stalls.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(entry_offset) && $stable(status))
        else $error("stalled result changed");

endmodule

// ===== test/tensor_layout_address_map_top_tb.sv =====
// ----------------------------------------------------------------------------
// tensor_layout_address_map_top_tb
// Self-checking bench: drives encode and decode commands through several
// layout settings and compares every result against an in-bench predictor.
// ----------------------------------------------------------------------------
module tensor_layout_address_map_top_tb;

    localparam int LATENCY = 4 + tlam_pkg::MAX_DIMS * 32;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] ca;
        logic signed [15:0] cb;
        logic signed [15:0] cc;
        logic signed [15:0] cd;
        logic [31:0]        lin;
    } item_t;

    typedef struct packed {
        logic [31:0]        ofs;
        logic signed [31:0] oa;
        logic signed [31:0] ob;
        logic signed [31:0] oc;
        logic signed [31:0] od;
        logic [1:0]         st;
    } addr_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] command = '0;
    logic signed [15:0] coord_a = '0, coord_b = '0, coord_c = '0, coord_d = '0;
    logic [31:0] linear_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [31:0] entry_offset;
    logic signed [31:0] out_a, out_b, out_c, out_d;
    logic [1:0] status;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    tensor_layout_address_map_top dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // layout copy held by the predictor
    logic [7:0]       lay_order;
    logic [3:0][15:0] lay_ext;
    logic [3:0][15:0] lay_pad;
    logic [3:0][31:0] lay_stride;

    item_t     pending_items[$];
    addr_res_t expected_addrs[$];
    int        mismatches = 0;
    longint    cycles = 0;
    bit        quiet_run = 0;   // long stretch with no idling

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic addr_res_t map_address(item_t it);
        addr_res_t r;
        longint crd[4], phys[4], res[4], p;
        logic [63:0] acc, rem, q;
        logic [1:0] f;
        bit zero;
        r = '0;
        acc = 0;
        crd[0] = it.ca; crd[1] = it.cb; crd[2] = it.cc; crd[3] = it.cd;
        for (int i = 0; i < 4; i++)
        begin
            phys[i] = 0;
            res[i] = 0;
        end
        if (it.cmd == tlam_pkg::CMD_LOG_ENC || it.cmd == tlam_pkg::CMD_PHY_ENC)
        begin
            for (int i = 0; i < 4; i++)
            begin
                f = lay_order[2*i +: 2];
                phys[i] = (it.cmd == tlam_pkg::CMD_LOG_ENC) ? crd[f] : crd[i];
                p = phys[i] + longint'(lay_pad[i]);
                if (p < 0 || p >= longint'(lay_ext[i]))
                    r.st = tlam_pkg::ST_OOB;
                acc += 64'(lay_stride[i]) * 64'(p);
            end
            r.ofs = acc[31:0];
        end
        else
        begin
            zero = 0;
            for (int i = 0; i < 4; i++)
                if (lay_stride[i] == 0)
                    zero = 1;
            if (zero)
                r.st = tlam_pkg::ST_ZERO;
            else
            begin
                rem = 64'(it.lin);
                for (int i = 0; i < 4; i++)
                begin
                    q = rem / 64'(lay_stride[i]);
                    if (q >= 64'(lay_ext[i]))
                        r.st = tlam_pkg::ST_OOB;
                    phys[i] = longint'(q) - longint'(lay_pad[i]);
                    rem = rem % 64'(lay_stride[i]);
                end
                // inverse permutation: later physical dim wins
                for (int i = 0; i < 4; i++)
                begin
                    f = lay_order[2*i +: 2];
                    if (it.cmd == tlam_pkg::CMD_LOG_DEC)
                        res[f] = phys[i];
                    else
                        res[i] = phys[i];
                end
                r.oa = sat32(res[0]);
                r.ob = sat32(res[1]);
                r.oc = sat32(res[2]);
                r.od = sat32(res[3]);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    function automatic bit idle_now();
        return !quiet_run && ($urandom_range(99) < 9);
    endfunction

    // driver: valid held until the transfer completes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && !idle_now())
                begin
                    item_t it;
                    it = pending_items.pop_front();
                    expected_addrs.push_back(map_address(it));
                    in_valid  <= 1'b1;
                    command   <= it.cmd;
                    coord_a   <= it.ca;
                    coord_b   <= it.cb;
                    coord_c   <= it.cc;
                    coord_d   <= it.cd;
                    linear_in <= it.lin;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result transfer, then picks the next ready level
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_addrs.size() == 0)
                    report_mismatch("unexpected result", 0, 0);
                else
                begin
                    addr_res_t e;
                    e = expected_addrs.pop_front();
                    if (entry_offset !== e.ofs) report_mismatch("entry_offset", entry_offset, e.ofs);
                    if (out_a !== e.oa) report_mismatch("out_a", out_a, e.oa);
                    if (out_b !== e.ob) report_mismatch("out_b", out_b, e.ob);
                    if (out_c !== e.oc) report_mismatch("out_c", out_c, e.oc);
                    if (out_d !== e.od) report_mismatch("out_d", out_d, e.od);
                    if (status !== e.st) report_mismatch("status", status, e.st);
                end
            end
            out_ready <= !idle_now();
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one register write over the config channel, mirrored in the predictor
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            tlam_pkg::REG_ORDER:   lay_order = val[7:0];
            tlam_pkg::REG_EXTENTS: lay_ext = val;
            tlam_pkg::REG_PADS:    lay_pad = val;
            tlam_pkg::REG_STRIDE0: lay_stride[0] = val[31:0];
            tlam_pkg::REG_STRIDE1: lay_stride[1] = val[31:0];
            tlam_pkg::REG_STRIDE2: lay_stride[2] = val[31:0];
            tlam_pkg::REG_STRIDE3: lay_stride[3] = val[31:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_addrs.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    function automatic item_t rand_item(bit tidy);
        item_t it;
        int r;
        it.cmd = 2'($urandom_range(3));
        if (tidy)
        begin
            // coordinates mostly inside the extents, offsets near the layout span
            it.ca = 16'($urandom_range(lay_ext[0] + 1) - lay_pad[0]);
            it.cb = 16'($urandom_range(lay_ext[1] + 1) - lay_pad[1]);
            it.cc = 16'($urandom_range(lay_ext[2] + 1) - lay_pad[2]);
            it.cd = 16'($urandom_range(lay_ext[3] + 1) - lay_pad[3]);
            r = $urandom_range(3);
            it.lin = (r == 0) ? $urandom() : $urandom_range(20000);
        end
        else
        begin
            it.ca = 16'($urandom()); it.cb = 16'($urandom());
            it.cc = 16'($urandom()); it.cd = 16'($urandom());
            it.lin = $urandom();
        end
        return it;
    endfunction

    task automatic queue_random(int n);
        for (int k = 0; k < n; k++)
            pending_items.push_back(rand_item($urandom_range(9) < 8));
    endtask

    initial
    begin
        item_t it;
        lay_order  = 8'd228;
        lay_ext    = 64'd281479271743489;
        lay_pad    = '0;
        lay_stride = {4{32'd1}};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset layout, extremes of every field and command
        for (int c = 0; c < 4; c++)
        begin
            it = '{cmd: c[1:0], ca: 16'sh7fff, cb: 16'sh8000, cc: 0, cd: -1,
                   lin: 32'hffffffff};
            pending_items.push_back(it);
            it = '{cmd: c[1:0], ca: 0, cb: 0, cc: 0, cd: 0, lin: 0};
            pending_items.push_back(it);
        end
        drain();

        // permuted layout with padding; out-of-bounds items, then a non-permutation order
        write_reg(tlam_pkg::REG_ORDER, 8'b00_01_10_11);
        write_reg(tlam_pkg::REG_EXTENTS, {16'd8, 16'd6, 16'd5, 16'd4});
        write_reg(tlam_pkg::REG_PADS, {16'd1, 16'd0, 16'd2, 16'd1});
        write_reg(tlam_pkg::REG_STRIDE3, 1);
        write_reg(tlam_pkg::REG_STRIDE2, 8);
        write_reg(tlam_pkg::REG_STRIDE1, 48);
        write_reg(tlam_pkg::REG_STRIDE0, 240);
        write_reg(3'd7, 64'hdead);  // undefined index: ignored
        for (int c = 0; c < 4; c++)
        begin
            it = '{cmd: c[1:0], ca: 1, cb: 2, cc: 3, cd: 4, lin: 32'd517};
            pending_items.push_back(it);
            it = '{cmd: c[1:0], ca: -2, cb: 9, cc: 3, cd: 7, lin: 32'd5000};
            pending_items.push_back(it);
        end
        queue_random(400);
        drain();

        write_reg(tlam_pkg::REG_ORDER, 8'b01_01_11_00);
        queue_random(300);
        drain();

        // zero stride: encode allowed, decode flagged
        write_reg(tlam_pkg::REG_STRIDE2, 0);
        queue_random(200);
        drain();

        // extremes of order, extents, pads and the first stride
        write_reg(tlam_pkg::REG_ORDER, 8'hff);
        write_reg(tlam_pkg::REG_EXTENTS, 64'hffff_ffff_ffff_ffff);
        write_reg(tlam_pkg::REG_PADS, 64'hffff_ffff_ffff_ffff);
        write_reg(tlam_pkg::REG_STRIDE0, 32'hffffffff);
        write_reg(tlam_pkg::REG_STRIDE1, 32'h10000);
        write_reg(tlam_pkg::REG_STRIDE2, 32'h100);
        write_reg(tlam_pkg::REG_STRIDE3, 32'h1);
        quiet_run = 1;
        queue_random(300);
        drain();
        quiet_run = 0;

        write_reg(tlam_pkg::REG_ORDER, 8'h00);
        write_reg(tlam_pkg::REG_EXTENTS, 64'h0);
        write_reg(tlam_pkg::REG_PADS, {16'd3, 16'h8000, 16'd0, 16'd7});
        write_reg(tlam_pkg::REG_STRIDE0, 32'h7fffffff);
        write_reg(tlam_pkg::REG_STRIDE3, 32'hffffffff);
        queue_random(420);
        drain();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== tensor_layout_address_map_top.f =====
rtl/core/tlam_pkg.sv
rtl/core/tlam_front.sv
rtl/core/tlam_div_stage.sv
rtl/core/tlam_back.sv
rtl/core/tensor_layout_address_map_top.sv
test/tensor_layout_address_map_top_tb.sv
